FILE: design/mipmapped_texture_sampler_defines.svh
// Assertion helpers used by the checker.
`ifndef MIPMAPPED_TEXTURE_SAMPLER_DEFINES_SVH
`define MIPMAPPED_TEXTURE_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MTS_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("texture sampler check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MTS_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("texture sampler check failed");

`endif

FILE: design/mts_pkg.sv
`default_nettype none
package mts_pkg;

  // operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_AT_LOD = 2'd2;
  localparam logic [1:0] OP_DERIV  = 2'd3;

  // filter codes
  localparam logic [1:0] FILT_POINT = 2'd0;
  localparam logic [1:0] FILT_BILIN = 2'd1;
  localparam logic [1:0] FILT_TRI   = 2'd2;

  // wrap codes
  localparam logic [1:0] WRAP_CLAMP  = 2'd0;
  localparam logic [1:0] WRAP_REPEAT = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODES  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIP_LEVELS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOD_BIAS    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LOD     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOD     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 4'd7;

  // one accepted input word
  typedef struct packed {
    logic [1:0]         op;
    logic signed [24:0] u;
    logic signed [24:0] v;
    logic signed [12:0] lod;
    logic signed [24:0] ddx_u;
    logic signed [24:0] ddx_v;
    logic signed [24:0] ddy_u;
    logic signed [24:0] ddy_v;
    logic [6:0]         texel_x;
    logic [6:0]         texel_y;
    logic [2:0]         texel_level;
    logic [31:0]        texel_rgba;
  } in_word_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       wr_en;
    logic       sq_en;
    logic [1:0] sq_idx;
    logic       msel;
    logic       norm8;
    logic       norm1;
    logic       log_load;
    logic       log_en;
    logic       lod_en;
    logic       setup_en;
    logic       wprep_en;
    logic       pass;
    logic       fetch_en;
    logic [1:0] fetch_idx;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       multi;
    logic       m_zero;
    logic       top8_zero;
    logic       top1;
    logic       point_mode;
    logic       trilin;
  } status_t;

  // texel words over all eight levels
  function automatic int store_depth(input int m);
    int d;
    int s;
    d = 0;
    for (int k = 0; k < 8; k++) begin
      s = (m > k) ? (m - k) : 0;
      d = d + (1 << (2 * s));
    end
    return d;
  endfunction

  // start address of each level, 32 bits per level, level 0 in the low word
  function automatic logic [255:0] base_table(input int m);
    logic [255:0] t;
    int b;
    int s;
    t = '0;
    b = 0;
    for (int k = 0; k < 8; k++) begin
      t[k*32 +: 32] = 32'(b);
      s = (m > k) ? (m - k) : 0;
      b = b + (1 << (2 * s));
    end
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: design/mts_in_if.sv
`default_nettype none
interface mts_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [24:0] u;
  logic signed [24:0] v;
  logic signed [12:0] lod;
  logic signed [24:0] ddx_u;
  logic signed [24:0] ddx_v;
  logic signed [24:0] ddy_u;
  logic signed [24:0] ddy_v;
  logic [6:0]         texel_x;
  logic [6:0]         texel_y;
  logic [2:0]         texel_level;
  logic [31:0]        texel_rgba;

  modport source (output valid, op, u, v, lod, ddx_u, ddx_v, ddy_u, ddy_v,
                  texel_x, texel_y, texel_level, texel_rgba, input ready);
  modport sink (input valid, op, u, v, lod, ddx_u, ddx_v, ddy_u, ddy_v,
                texel_x, texel_y, texel_level, texel_rgba, output ready);
endinterface
`default_nettype wire

FILE: design/mts_out_if.sv
`default_nettype none
interface mts_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rgba;
  logic        is_write_ack;
  logic        bad_write;

  modport source (output valid, rgba, is_write_ack, bad_write, input ready);
  modport sink (input valid, rgba, is_write_ack, bad_write, output ready);
endinterface
`default_nettype wire

FILE: design/mts_cfg_if.sv
`default_nettype none
interface mts_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/mts_ctrl.sv
`default_nettype none
module mts_ctrl
  import mts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_MSEL  = 4'd4;
  localparam logic [3:0] S_NORM8 = 4'd5;
  localparam logic [3:0] S_NORM1 = 4'd6;
  localparam logic [3:0] S_LOGL  = 4'd7;
  localparam logic [3:0] S_LOG   = 4'd8;
  localparam logic [3:0] S_LOD   = 4'd9;
  localparam logic [3:0] S_SETUP = 4'd10;
  localparam logic [3:0] S_WPREP = 4'd11;
  localparam logic [3:0] S_FETCH = 4'd12;
  localparam logic [3:0] S_DRAIN = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_space;

  assign out_space = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // sequencing
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pass_nxt  = pass_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (status.op == OP_WRITE) begin
          state_nxt = S_WRITE;
        end else if (status.op == OP_DERIV && status.multi) begin
          state_nxt = S_SQ;
          step_nxt  = 3'd0;
        end else begin
          state_nxt = S_LOD;
        end
      end
      S_WRITE: state_nxt = S_DONE;
      S_SQ: begin
        if (step_r == 3'd3) state_nxt = S_MSEL;
        else step_nxt = step_r + 3'd1;
      end
      S_MSEL: state_nxt = S_NORM8;
      S_NORM8: begin
        if (status.m_zero) state_nxt = S_LOD;
        else if (!status.top8_zero) state_nxt = S_NORM1;
      end
      S_NORM1: begin
        if (status.top1) state_nxt = S_LOGL;
      end
      S_LOGL: begin
        state_nxt = S_LOG;
        step_nxt  = 3'd0;
      end
      S_LOG: begin
        if (step_r == 3'd6) state_nxt = S_LOD;
        else step_nxt = step_r + 3'd1;
      end
      S_LOD: begin
        state_nxt = S_SETUP;
        pass_nxt  = 1'b0;
      end
      S_SETUP: state_nxt = S_WPREP;
      S_WPREP: begin
        state_nxt = S_FETCH;
        step_nxt  = 3'd0;
      end
      S_FETCH: begin
        if (status.point_mode || step_r == 3'd3) state_nxt = S_DRAIN;
        else step_nxt = step_r + 3'd1;
      end
      S_DRAIN: begin
        if (!pass_r && status.trilin) begin
          pass_nxt  = 1'b1;
          state_nxt = S_SETUP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_space) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.wr_en     = (state_r == S_WRITE);
    cmd.sq_en     = (state_r == S_SQ);
    cmd.sq_idx    = step_r[1:0];
    cmd.msel      = (state_r == S_MSEL);
    cmd.norm8     = (state_r == S_NORM8) && !status.m_zero && status.top8_zero;
    cmd.norm1     = (state_r == S_NORM1) && !status.top1;
    cmd.log_load  = (state_r == S_LOGL);
    cmd.log_en    = (state_r == S_LOG);
    cmd.lod_en    = (state_r == S_LOD);
    cmd.setup_en  = (state_r == S_SETUP);
    cmd.wprep_en  = (state_r == S_WPREP);
    cmd.pass      = pass_r;
    cmd.fetch_en  = (state_r == S_FETCH);
    cmd.fetch_idx = step_r[1:0];
    cmd.out_load  = (state_r == S_DONE) && out_space;
  end

  // result word held until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 3'd0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/mts_dp.sv
`default_nettype none
module mts_dp
  import mts_pkg::*;
#(
  parameter int MAX_SIZE_LOG2   = 7,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  in_word_t              in_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [31:0]           out_rgba,
  output logic                  out_is_write_ack,
  output logic                  out_bad_write
);

  localparam int M     = MAX_SIZE_LOG2;
  localparam int CFB   = COORD_FRAC_BITS;
  localparam int DEPTH = store_depth(MAX_SIZE_LOG2);
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = MAX_SIZE_LOG2;
  localparam int QW    = 26 + MAX_SIZE_LOG2;
  localparam logic [255:0] BASE_TBL = base_table(MAX_SIZE_LOG2);
  localparam logic signed [QW-1:0] HALF = QW'(1) <<< (CFB - 1);
  localparam logic signed [15:0] LOG_OFS = 16'(256 * COORD_FRAC_BITS);

  // size log2 of a level, base capped at the largest size
  function automatic logic [3:0] lvl_lg(input logic [2:0] base_lg, input logic [2:0] lvl);
    int b;
    b = (int'(base_lg) > M) ? M : int'(base_lg);
    if (int'(lvl) >= b) return 4'd0;
    return 4'(b - int'(lvl));
  endfunction

  function automatic logic [AW-1:0] texel_addr(input logic [2:0] lvl, input logic [31:0] y,
                                               input logic [31:0] x);
    int s;
    logic [31:0] a;
    s = (int'(lvl) >= M) ? 0 : (M - int'(lvl));
    a = BASE_TBL[lvl*32 +: 32] + (y << s) + x;
    return a[AW-1:0];
  endfunction

  // clamp to edge, repeat, mirrored repeat on an integer index
  function automatic logic [IW-1:0] wrap_ix(input logic signed [QW-1:0] i,
                                            input logic [3:0] lg, input logic [1:0] mode);
    logic [IW+1:0] n;
    logic [IW+1:0] t;
    logic [IW+1:0] r;
    n = (IW+2)'(1) << lg;
    r = '0;
    case (mode)
      WRAP_CLAMP: begin
        if (i < 0) r = '0;
        else if (i >= $signed(QW'(n))) r = n - (IW+2)'(1);
        else r = i[IW+1:0];
      end
      WRAP_MIRROR: begin
        t = i[IW+1:0] & ((n << 1) - (IW+2)'(1));
        if (t >= n) r = (n << 1) - (IW+2)'(1) - t;
        else r = t;
      end
      default: r = i[IW+1:0] & (n - (IW+2)'(1));
    endcase
    return r[IW-1:0];
  endfunction

  // configuration registers
  logic [1:0]         filter_r;
  logic [3:0]         wrap_r;
  logic [3:0]         mipl_r;
  logic signed [12:0] bias_r, minl_r, maxl_r;
  logic [2:0]         wlg_r, hlg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= FILT_BILIN;
      wrap_r   <= 4'd5;
      mipl_r   <= 4'd1;
      bias_r   <= 13'sd0;
      minl_r   <= 13'sd0;
      maxl_r   <= 13'sd4095;
      wlg_r    <= 3'd7;
      hlg_r    <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE: filter_r <= cfg_data[1:0];
        REG_WRAP_MODES:  wrap_r   <= cfg_data[3:0];
        REG_MIP_LEVELS:  mipl_r   <= cfg_data[3:0];
        REG_LOD_BIAS:    bias_r   <= $signed(cfg_data);
        REG_MIN_LOD:     minl_r   <= $signed(cfg_data);
        REG_MAX_LOD:     maxl_r   <= $signed(cfg_data);
        REG_WIDTH_LOG2:  wlg_r    <= cfg_data[2:0];
        REG_HEIGHT_LOG2: hlg_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // level count, zero acts as one and large values as eight
  logic [3:0] cnt;
  logic       multi;
  assign cnt   = (mipl_r == 4'd0) ? 4'd1 : ((mipl_r > 4'd8) ? 4'd8 : mipl_r);
  assign multi = (cnt > 4'd1);

  // captured word
  in_word_t w_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) w_r <= in_word;
  end

  // shared squarer
  logic [31:0]        mul_a;
  logic [63:0]        prod;
  logic signed [24:0] dsel;
  logic [24:0]        dmag;
  logic [31:0]        x_r;

  always_comb begin
    case (cmd.sq_idx)
      2'd0:    dsel = w_r.ddx_u;
      2'd1:    dsel = w_r.ddx_v;
      2'd2:    dsel = w_r.ddy_u;
      default: dsel = w_r.ddy_v;
    endcase
    dmag  = dsel[24] ? 25'(-dsel) : 25'(dsel);
    mul_a = cmd.sq_en ? 32'(dmag) : x_r;
    prod  = mul_a * mul_a;
  end

  // derivative magnitudes and log2 by normalize and repeated squaring
  logic [49:0] sx_r, sy_r;
  logic [63:0] m_r, sxl, syl, m_nxt;
  logic        mzero_r;
  logic [5:0]  p_r;
  logic [6:0]  frac_r;
  logic [3:0]  wl0, hl0;

  assign wl0   = lvl_lg(wlg_r, 3'd0);
  assign hl0   = lvl_lg(hlg_r, 3'd0);
  assign sxl   = 64'(sx_r) << {wl0, 1'b0};
  assign syl   = 64'(sy_r) << {hl0, 1'b0};
  assign m_nxt = (sxl > syl) ? sxl : syl;

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      case (cmd.sq_idx)
        2'd0:    sx_r <= prod[49:0];
        2'd1:    sx_r <= sx_r + prod[49:0];
        2'd2:    sy_r <= prod[49:0];
        default: sy_r <= sy_r + prod[49:0];
      endcase
    end
    if (cmd.msel) begin
      m_r     <= m_nxt;
      mzero_r <= (m_nxt == 64'd0);
      p_r     <= 6'd63;
    end else if (cmd.norm8) begin
      m_r <= m_r << 8;
      p_r <= p_r - 6'd8;
    end else if (cmd.norm1) begin
      m_r <= m_r << 1;
      p_r <= p_r - 6'd1;
    end
    if (cmd.log_load) begin
      x_r    <= m_r[63:32];
      frac_r <= 7'd0;
    end else if (cmd.log_en) begin
      frac_r <= {frac_r[5:0], prod[63]};
      x_r    <= prod[63] ? prod[63:32] : prod[62:31];
    end
  end

  // level of detail select and clamp
  logic signed [15:0] base16, raw, hi, lx;
  logic [10:0]        lod_nxt, lod_r;
  logic               use_lod;

  always_comb begin
    base16 = $signed(16'({p_r, frac_r})) - LOG_OFS;
    if (mzero_r || base16 < 0) base16 = 16'sd0;
    case (w_r.op)
      OP_AT_LOD: raw = 16'(w_r.lod) + 16'(bias_r);
      OP_DERIV:  raw = base16 + 16'(bias_r);
      default:   raw = 16'(bias_r);
    endcase
    hi = $signed(16'({cnt - 4'd1, 8'd0}));
    if (16'(maxl_r) < hi) hi = 16'(maxl_r);
    lx = raw;
    if (lx < 16'(minl_r)) lx = 16'(minl_r);
    if (lx > hi) lx = hi;
    if (lx < 0) lx = 16'sd0;
    use_lod = multi && !(w_r.op == OP_BIAS && filter_r != FILT_TRI);
    lod_nxt = use_lod ? lx[10:0] : 11'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.lod_en) lod_r <= lod_nxt;
  end

  // level pair for the blend
  logic [2:0] l0, l1;
  logic [3:0] l0p;
  logic       point_mode, trilin;
  logic [7:0] fw;

  assign l0         = lod_r[10:8];
  assign l0p        = {1'b0, l0} + 4'd1;
  assign l1         = (l0p > cnt - 4'd1) ? 3'(cnt - 4'd1) : l0p[2:0];
  assign fw         = lod_r[7:0];
  assign point_mode = (filter_r == FILT_POINT);
  assign trilin     = (filter_r == FILT_TRI) && multi && (l0 != l1);

  // per-level coordinate setup
  logic [2:0]            lvl, lvl_r;
  logic [3:0]            wlx, wly;
  logic signed [QW-1:0]  uq, vq, x0, y0, x1, y1;
  logic [IW-1:0]         xa_r, xb_r, ya_r, yb_r;
  logic [7:0]            wx_r, wy_r;
  logic [8:0]            lf_r;
  logic [16:0]           lx0_r, lx1_r;

  always_comb begin
    lvl = cmd.pass ? l1 : l0;
    wlx = lvl_lg(wlg_r, lvl);
    wly = lvl_lg(hlg_r, lvl);
    uq  = (QW'(w_r.u) <<< wlx) - (point_mode ? QW'(0) : HALF);
    vq  = (QW'(w_r.v) <<< wly) - (point_mode ? QW'(0) : HALF);
    x0  = uq >>> CFB;
    y0  = vq >>> CFB;
    x1  = x0 + QW'(1);
    y1  = y0 + QW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup_en) begin
      lvl_r <= lvl;
      xa_r  <= wrap_ix(x0, wlx, wrap_r[1:0]);
      xb_r  <= wrap_ix(x1, wlx, wrap_r[1:0]);
      ya_r  <= wrap_ix(y0, wly, wrap_r[3:2]);
      yb_r  <= wrap_ix(y1, wly, wrap_r[3:2]);
      wx_r  <= point_mode ? 8'd0 : uq[CFB-1 -: 8];
      wy_r  <= point_mode ? 8'd0 : vq[CFB-1 -: 8];
      if (cmd.pass) lf_r <= {1'b0, fw};
      else lf_r <= trilin ? (9'd256 - {1'b0, fw}) : 9'd256;
    end
    if (cmd.wprep_en) begin
      lx0_r <= 17'((9'd256 - {1'b0, wx_r}) * lf_r);
      lx1_r <= 17'({1'b0, wx_r} * lf_r);
    end
  end

  // texel memory, one port
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_r;
  logic [AW-1:0] addr, raddr, waddr;
  logic [IW-1:0] fx, fy;
  logic [3:0]    twl, thl;
  logic          bad, bad_r;

  assign fx    = cmd.fetch_idx[0] ? xb_r : xa_r;
  assign fy    = cmd.fetch_idx[1] ? yb_r : ya_r;
  assign raddr = texel_addr(lvl_r, 32'(fy), 32'(fx));
  assign twl   = lvl_lg(wlg_r, w_r.texel_level);
  assign thl   = lvl_lg(hlg_r, w_r.texel_level);
  assign bad   = ((32'(w_r.texel_x) >> twl) != 32'd0) || ((32'(w_r.texel_y) >> thl) != 32'd0);
  assign waddr = texel_addr(w_r.texel_level, 32'(w_r.texel_y), 32'(w_r.texel_x));
  assign addr  = cmd.wr_en ? waddr : raddr;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && !bad) mem[addr] <= w_r.texel_rgba;
    rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) bad_r <= bad;
  end

  // weighted accumulate, one texel per cycle behind the read
  logic [25:0] wprod;
  logic [24:0] wt_r;
  logic        acc_vld_r;
  logic [31:0] acc_r [4];

  assign wprod = (cmd.fetch_idx[0] ? lx1_r : lx0_r) *
                 (cmd.fetch_idx[1] ? {1'b0, wy_r} : (9'd256 - {1'b0, wy_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) acc_vld_r <= 1'b0;
    else acc_vld_r <= cmd.fetch_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_en) wt_r <= wprod[24:0];
    for (int c = 0; c < 4; c++) begin
      if (cmd.lod_en) acc_r[c] <= 32'd0;
      else if (acc_vld_r) acc_r[c] <= acc_r[c] + 32'(rdata_r[8*c +: 8] * wt_r);
    end
  end

  // result word
  logic [31:0] color;
  logic [31:0] rnd [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rnd[c] = acc_r[c] + 32'h0080_0000;
      color[8*c +: 8] = rnd[c][31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (w_r.op == OP_WRITE) begin
        out_rgba         <= 32'd0;
        out_is_write_ack <= 1'b1;
        out_bad_write    <= bad_r;
      end else begin
        out_rgba         <= color;
        out_is_write_ack <= 1'b0;
        out_bad_write    <= 1'b0;
      end
    end
  end

  assign status.op         = w_r.op;
  assign status.multi      = multi;
  assign status.m_zero     = mzero_r;
  assign status.top8_zero  = (m_r[63:56] == 8'd0);
  assign status.top1       = m_r[63];
  assign status.point_mode = point_mode;
  assign status.trilin     = trilin;

endmodule
`default_nettype wire

FILE: design/mipmapped_texture_sampler.sv
// Channel   Dir  Handshake        Word
// in_ch     in   valid/ready      op, u, v, lod, derivatives, texel write fields
// out_ch    out  valid/ready      rgba, is_write_ack, bad_write
// cfg_ch    in   valid/ready      index, data (ready always high)
//
// One item at a time. Derivative LOD computes four squares, normalizes in 8-bit then
// 1-bit steps and runs seven log squarings, all on one multiplier; zero derivatives
// skip the normalize and log steps. The single-port texel memory gives one texel
// read per cycle. Synchronous active-low reset sets the control and configuration
// registers to their defaults; texel memory is not cleared. A held result does not
// block the next accept.
`default_nettype none
module mipmapped_texture_sampler
  import mts_pkg::*;
#(
  parameter int MAX_SIZE_LOG2   = 7,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch,
  mts_cfg_if.sink   cfg_ch
);

  cmd_t     cmd;
  status_t  status;
  in_word_t in_word;

  assign in_word.op          = in_ch.op;
  assign in_word.u           = in_ch.u;
  assign in_word.v           = in_ch.v;
  assign in_word.lod         = in_ch.lod;
  assign in_word.ddx_u       = in_ch.ddx_u;
  assign in_word.ddx_v       = in_ch.ddx_v;
  assign in_word.ddy_u       = in_ch.ddy_u;
  assign in_word.ddy_v       = in_ch.ddy_v;
  assign in_word.texel_x     = in_ch.texel_x;
  assign in_word.texel_y     = in_ch.texel_y;
  assign in_word.texel_level = in_ch.texel_level;
  assign in_word.texel_rgba  = in_ch.texel_rgba;

  assign cfg_ch.ready = 1'b1;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mts_dp #(
    .MAX_SIZE_LOG2   (MAX_SIZE_LOG2),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_word          (in_word),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_rgba         (out_ch.rgba),
    .out_is_write_ack (out_ch.is_write_ack),
    .out_bad_write    (out_ch.bad_write)
  );

endmodule
`default_nettype wire

FILE: design/mts_checker.sv
`default_nettype none
`include "mipmapped_texture_sampler_defines.svh"
module mts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_rgba,
  input logic        out_is_write_ack,
  input logic        out_bad_write
);

  // a pending result word stays up
  `MTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // one item in flight: accept closes the input side
  `MTS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // write answers carry no color
  `MTS_ASSERT_IMP(a_ack_no_color, out_valid && out_is_write_ack, out_rgba == 32'd0)

  // a dropped write is always a write answer
  `MTS_ASSERT_IMP(a_bad_is_ack, out_valid && out_bad_write, out_is_write_ack)

endmodule

bind mipmapped_texture_sampler mts_checker u_mts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_rgba         (out_ch.rgba),
  .out_is_write_ack (out_ch.is_write_ack),
  .out_bad_write    (out_ch.bad_write)
);
`default_nettype wire
